// ===== rtl/core/playfair_encrypt_unit_macros.svh =====
// Assertion macros shared by the Playfair encryptor RTL.
`ifndef PLAYFAIR_ENCRYPT_UNIT_MACROS_SVH
`define PLAYFAIR_ENCRYPT_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked property, skipped while reset is asserted.
`define PFE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property with a guard that the caller supplies.
`define PFE_ASSERT_WHEN(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> prop) else $error(msg);

`else

`define PFE_ASSERT(lbl, clk, rst_n, prop, msg)
`define PFE_ASSERT_WHEN(lbl, clk, rst_n, cond, prop, msg)

`endif

`endif

// ===== rtl/core/pfe_pkg.sv =====
// Shared types, constants and letter helpers of the Playfair encryptor.
package pfe_pkg;

    localparam int unsigned LETTER_W  = 5;
    localparam int unsigned CELLS     = 25;
    localparam int unsigned SIDE      = 5;
    localparam int unsigned CMD_DEPTH = 4;
    localparam int unsigned RES_DEPTH = 4;

    localparam logic [LETTER_W-1:0] CODE_A = 5'd0;
    localparam logic [LETTER_W-1:0] CODE_I = 5'd8;
    localparam logic [LETTER_W-1:0] CODE_J = 5'd9;
    localparam logic [LETTER_W-1:0] CODE_Q = 5'd16;
    localparam logic [LETTER_W-1:0] CODE_X = 5'd23;
    localparam logic [LETTER_W-1:0] CODE_Z = 5'd25;

    // Input operation codes.
    typedef enum logic [1:0] {
        OP_KEY  = 2'd0,
        OP_FILL = 2'd1,
        OP_TEXT = 2'd2,
        OP_END  = 2'd3
    } t_op;

    // Commands passed from the front end to the back end.
    typedef enum logic [1:0] {
        CMD_PLACE = 2'd0,
        CMD_FILL  = 2'd1,
        CMD_ENC   = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        logic [1:0]          op;
        logic [LETTER_W-1:0] in_letter;
    } t_in_item;

    typedef struct packed {
        logic [LETTER_W-1:0] out_letter;
        logic                last;
    } t_out_item;

    typedef struct packed {
        t_cmd_kind           kind;
        logic [LETTER_W-1:0] a;
        logic [LETTER_W-1:0] b;
    } t_cmd;

    // Clamp a code to Z and fold J onto I.
    function automatic logic [LETTER_W-1:0] fold_letter(input logic [LETTER_W-1:0] v);
        logic [LETTER_W-1:0] c;
        c = (v > CODE_Z) ? CODE_Z : v;
        return (c == CODE_J) ? CODE_I : c;
    endfunction

    // Folded letter to its slot 0..24 in the used and position maps.
    function automatic logic [LETTER_W-1:0] slot_of(input logic [LETTER_W-1:0] c);
        return (c > CODE_J) ? c - 5'd1 : c;
    endfunction

endpackage

// ===== rtl/core/playfair_encrypt_unit.sv =====
// Top level of the Playfair encryptor: front end, command queue, back end, result queue.
//
//  channel   direction  handshake      payload
//  input     in         push / full    i_in  (op, in_letter)
//  result    out        pop / empty    o_out (out_letter, last)
//
// The front end takes one request a cycle until the command queue is full.
// The back end places a key letter as it pops it; a key-done fill pops, then walks
// the alphabet in 26 steps; a digraph takes two position reads, then two square
// reads on one port.
// A text letter that only opens a digraph costs the back end nothing.
// Reset is synchronous and active low; it clears the used-letter map at once.
// A full result queue stalls the back end; the command queue keeps taking requests.
module playfair_encrypt_unit #(
    parameter int unsigned CMD_DEPTH = pfe_pkg::CMD_DEPTH,
    parameter int unsigned RES_DEPTH = pfe_pkg::RES_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  pfe_pkg::t_in_item  i_in,
    input  logic               pop,
    output logic               empty,
    output pfe_pkg::t_out_item o_out
);

    import pfe_pkg::*;

    localparam int unsigned CMD_W = $bits(t_cmd);
    localparam int unsigned RES_W = $bits(t_out_item);

    logic             accept;
    t_cmd             front_cmd;
    logic             front_cmd_valid;
    logic [CMD_W-1:0] cmd_q_data;
    logic             cmd_empty;
    t_cmd             back_cmd;
    logic             back_cmd_pop;
    logic             res_full;
    logic             res_push;
    t_out_item        back_res;
    logic [RES_W-1:0] res_q_data;

    assign accept   = push && !full;
    assign back_cmd = t_cmd'(cmd_q_data);
    assign o_out    = t_out_item'(res_q_data);

    // Request classification and digraph forming.
    pfe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_in),
        .o_cmd       (front_cmd),
        .o_cmd_valid (front_cmd_valid)
    );

    // Commands waiting for the back end.
    pfe_queue #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_cmd_valid),
        .i_data  (CMD_W'(front_cmd)),
        .o_full  (full),
        .i_rd    (back_cmd_pop),
        .o_empty (cmd_empty),
        .o_data  (cmd_q_data)
    );

    // Square building and enciphering.
    pfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!cmd_empty),
        .i_cmd       (back_cmd),
        .o_cmd_pop   (back_cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (back_res)
    );

    // Finished letters waiting to be taken.
    pfe_queue #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_push),
        .i_data  (RES_W'(back_res)),
        .o_full  (res_full),
        .i_rd    (pop),
        .o_empty (empty),
        .o_data  (res_q_data)
    );

endmodule

// ===== rtl/core/pfe_queue.sv =====
// Small first-in first-out queue with the head shown combinationally.
`include "playfair_encrypt_unit_macros.svh"

module pfe_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_rd,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_fire;
    logic             rd_fire;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_fire = i_wr && !o_full;
    assign rd_fire = i_rd && !o_empty;

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_fire) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (rd_fire) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (wr_fire && !rd_fire) begin
                r_count <= r_count + 1'b1;
            end else if (rd_fire && !wr_fire) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `PFE_ASSERT(a_count_bound, i_clk, i_rst_n, (r_count <= CNT_W'(DEPTH)), "queue count overflow")
    `PFE_ASSERT_WHEN(a_count_step, i_clk, i_rst_n, $past(i_rst_n), (r_count == $past(r_count) + CNT_W'($past(wr_fire)) - CNT_W'($past(rd_fire))), "queue count step wrong")
    `PFE_ASSERT_WHEN(a_head_data, i_clk, i_rst_n, $past(i_rst_n) && $past(wr_fire) && $past(o_empty), (o_data == $past(i_data)), "queue head lost write")

endmodule

// ===== rtl/core/pfe_front.sv =====
// Front end: classifies requests and forms digraphs with their padding.
module pfe_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  pfe_pkg::t_in_item i_item,
    output pfe_pkg::t_cmd   o_cmd,
    output logic            o_cmd_valid
);

    import pfe_pkg::*;

    logic [LETTER_W-1:0] r_pend_letter;
    logic [LETTER_W-1:0] n_pend_letter;
    logic                r_pend_valid;
    logic                n_pend_valid;
    logic [LETTER_W-1:0] letter;
    logic [LETTER_W-1:0] pad;

    assign letter = fold_letter(i_item.in_letter);
    assign pad    = (letter == CODE_X) ? CODE_Q : CODE_X;

    // Decide the command for the accepted request and the open digraph.
    always_comb begin
        n_pend_letter = r_pend_letter;
        n_pend_valid  = r_pend_valid;
        o_cmd_valid   = 1'b0;
        o_cmd.kind    = CMD_PLACE;
        o_cmd.a       = letter;
        o_cmd.b       = pad;
        case (t_op'(i_item.op))
            OP_KEY: begin
                o_cmd_valid = i_accept;
            end
            OP_FILL: begin
                o_cmd.kind  = CMD_FILL;
                o_cmd_valid = i_accept;
            end
            OP_TEXT: begin
                o_cmd.kind = CMD_ENC;
                if (!r_pend_valid) begin
                    n_pend_letter = letter;
                    n_pend_valid  = 1'b1;
                end else if (r_pend_letter == letter) begin
                    // A doubled letter is split; the second copy stays open.
                    o_cmd_valid = i_accept;
                end else begin
                    o_cmd.a      = r_pend_letter;
                    o_cmd.b      = letter;
                    o_cmd_valid  = i_accept;
                    n_pend_valid = 1'b0;
                end
            end
            OP_END: begin
                o_cmd.kind   = CMD_ENC;
                o_cmd.a      = r_pend_letter;
                o_cmd.b      = CODE_X;
                o_cmd_valid  = i_accept && r_pend_valid;
                n_pend_valid = 1'b0;
            end
            default: begin
                o_cmd_valid = 1'b0;
            end
        endcase
    end

    // Open digraph state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_accept) begin
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_pend_letter <= n_pend_letter;
        end
    end

endmodule

// ===== rtl/core/pfe_back.sv =====
// Back end: builds the key square and enciphers digraphs from the command queue.
`include "playfair_encrypt_unit_macros.svh"

module pfe_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  pfe_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    input  logic               i_res_full,
    output logic               o_res_push,
    output pfe_pkg::t_out_item o_res
);

    import pfe_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_FILL = 6'b000010,
        S_POSA = 6'b000100,
        S_POSB = 6'b001000,
        S_OUTA = 6'b010000,
        S_OUTB = 6'b100000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [LETTER_W-1:0] r_fill;
    logic [LETTER_W-1:0] r_k;
    logic [LETTER_W-1:0] n_k;
    logic [CELLS-1:0]    r_used;
    logic [LETTER_W-1:0] r_b;
    logic [LETTER_W-1:0] n_b;
    logic [LETTER_W-1:0] r_pa;
    logic [LETTER_W-1:0] n_pa;
    logic [LETTER_W-1:0] r_qb;
    logic [LETTER_W-1:0] n_qb;

    // Square and position stores, one read and one write port each.
    logic [LETTER_W-1:0] r_sq_mem  [CELLS];
    logic [LETTER_W-1:0] r_pos_mem [CELLS];
    logic [LETTER_W-1:0] r_sq_rd;
    logic [LETTER_W-1:0] r_pos_rd;

    logic                place_req;
    logic [LETTER_W-1:0] place_letter;
    logic [LETTER_W-1:0] place_slot;
    logic                place_go;
    logic                pos_rd_en;
    logic [LETTER_W-1:0] pos_rd_addr;
    logic                sq_rd_en;
    logic [LETTER_W-1:0] sq_rd_addr;

    logic [LETTER_W-1:0] pb;
    logic [2:0]          ra;
    logic [2:0]          ca;
    logic [2:0]          rb;
    logic [2:0]          cb;
    logic [2:0]          qra;
    logic [2:0]          qca;
    logic [2:0]          qrb;
    logic [2:0]          qcb;

    // Keep a position inside the square.
    function automatic logic [LETTER_W-1:0] cell_wrap(input logic [LETTER_W-1:0] p);
        return (p >= LETTER_W'(CELLS)) ? p - LETTER_W'(CELLS) : p;
    endfunction

    function automatic logic [2:0] row_of(input logic [LETTER_W-1:0] p);
        logic [2:0] r;
        if (p >= LETTER_W'(4 * SIDE)) begin
            r = 3'd4;
        end else if (p >= LETTER_W'(3 * SIDE)) begin
            r = 3'd3;
        end else if (p >= LETTER_W'(2 * SIDE)) begin
            r = 3'd2;
        end else if (p >= LETTER_W'(SIDE)) begin
            r = 3'd1;
        end else begin
            r = 3'd0;
        end
        return r;
    endfunction

    function automatic logic [LETTER_W-1:0] times_side(input logic [2:0] r);
        return {r, 2'b00} + {2'b00, r};
    endfunction

    function automatic logic [2:0] col_of(input logic [LETTER_W-1:0] p);
        logic [LETTER_W-1:0] d;
        d = p - times_side(row_of(p));
        return d[2:0];
    endfunction

    function automatic logic [2:0] step_wrap(input logic [2:0] x);
        return (x == 3'(SIDE - 1)) ? 3'd0 : x + 3'd1;
    endfunction

    // Corner, row and column rules on the two positions.
    assign pb = cell_wrap(r_pos_rd);
    assign ra = row_of(r_pa);
    assign ca = col_of(r_pa);
    assign rb = row_of(pb);
    assign cb = col_of(pb);

    always_comb begin
        if (ra == rb) begin
            qra = ra;
            qca = step_wrap(ca);
            qrb = rb;
            qcb = step_wrap(cb);
        end else if (ca == cb) begin
            qra = step_wrap(ra);
            qca = ca;
            qrb = step_wrap(rb);
            qcb = cb;
        end else begin
            qra = ra;
            qca = cb;
            qrb = rb;
            qcb = ca;
        end
    end

    // Letter placement, shared by key letters and the fill walk.
    assign place_letter = (r_state == S_FILL) ? r_k : i_cmd.a;
    assign place_slot   = slot_of(place_letter);
    assign place_go     = place_req && (r_fill < LETTER_W'(CELLS)) && !r_used[place_slot];

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_b         = r_b;
        n_pa        = r_pa;
        n_qb        = r_qb;
        o_cmd_pop   = 1'b0;
        place_req   = 1'b0;
        pos_rd_en   = 1'b0;
        pos_rd_addr = slot_of(i_cmd.a);
        sq_rd_en    = 1'b0;
        sq_rd_addr  = r_qb;
        o_res_push  = 1'b0;
        o_res.out_letter = r_sq_rd;
        o_res.last       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.kind)
                        CMD_PLACE: begin
                            place_req = 1'b1;
                        end
                        CMD_FILL: begin
                            n_k     = CODE_A;
                            n_state = S_FILL;
                        end
                        CMD_ENC: begin
                            pos_rd_en = 1'b1;
                            n_b       = i_cmd.b;
                            n_state   = S_POSA;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_FILL: begin
                // Walk the alphabet once, skipping J.
                place_req = (r_k != CODE_J);
                if (r_k == CODE_Z) begin
                    n_state = S_IDLE;
                end else begin
                    n_k = r_k + 5'd1;
                end
            end
            S_POSA: begin
                n_pa        = cell_wrap(r_pos_rd);
                pos_rd_en   = 1'b1;
                pos_rd_addr = slot_of(r_b);
                n_state     = S_POSB;
            end
            S_POSB: begin
                sq_rd_en   = 1'b1;
                sq_rd_addr = times_side(qra) + {2'b00, qca};
                n_qb       = times_side(qrb) + {2'b00, qcb};
                n_state    = S_OUTA;
            end
            S_OUTA: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    sq_rd_en   = 1'b1;
                    n_state    = S_OUTB;
                end
            end
            S_OUTB: begin
                o_res.last = 1'b1;
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            if (place_go) begin
                r_fill             <= r_fill + 5'd1;
                r_used[place_slot] <= 1'b1;
            end
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_k  <= n_k;
        r_b  <= n_b;
        r_pa <= n_pa;
        r_qb <= n_qb;
    end

    // Store writes.
    always_ff @(posedge i_clk) begin
        if (place_go) begin
            r_sq_mem[r_fill]      <= place_letter;
            r_pos_mem[place_slot] <= r_fill;
        end
    end

    // Store reads, registered.
    always_ff @(posedge i_clk) begin
        if (pos_rd_en) begin
            r_pos_rd <= r_pos_mem[pos_rd_addr];
        end
        if (sq_rd_en) begin
            r_sq_rd <= r_sq_mem[sq_rd_addr];
        end
    end

    `PFE_ASSERT(a_fill_bound, i_clk, i_rst_n, (r_fill <= LETTER_W'(CELLS)), "fill index beyond square")
    `PFE_ASSERT_WHEN(a_fill_step, i_clk, i_rst_n, $past(i_rst_n) && (r_fill != $past(r_fill)), (r_fill == $past(r_fill) + 5'd1), "fill index jumped")
    `PFE_ASSERT_WHEN(a_second_letter, i_clk, i_rst_n, $past(i_rst_n) && (r_state == S_OUTB), (($past(r_state) == S_OUTA) || ($past(r_state) == S_OUTB)), "second letter without first")

endmodule
